>>> src/lrukv_pkg.sv
// Package: shared constants, codes and lane command type for the LRU key/data store.
package lrukv_pkg;

  // Capacity register
  localparam int unsigned CAP_W = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  // Request mode codes
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_WRITE  = 1'b1;

  // Per-lane update command, broadcast from the control pass to each entry
  typedef struct packed {
    logic promote;  // a hit happens somewhere: age entries more recent than it
    logic age;      // an insert happens: age every valid entry
    logic sel;      // this lane holds the hit key
    logic wr;       // the request is a write
    logic drop;     // this lane is evicted
    logic fill;     // this lane takes the new key
  } lane_cmd_t;

endpackage

>>> src/lrukv_ifs.sv
// Interfaces: request, result and capacity write channels.
interface lrukv_req_if
  import lrukv_pkg::*;
#(
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned DATA_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [KEY_BITS-1:0]  key;
  logic [DATA_BITS-1:0] write_data;

  modport source (output valid, output mode, output key, output write_data, input ready);
  modport sink   (input valid, input mode, input key, input write_data, output ready);
endinterface

interface lrukv_rsp_if
  import lrukv_pkg::*;
#(
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned DATA_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [DATA_BITS-1:0] read_data;
  logic                 evicted;
  logic [KEY_BITS-1:0]  evicted_key;

  modport source (output valid, output hit, output read_data, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_data, input evicted,
                  input evicted_key, output ready);
endinterface

interface lrukv_cfg_if
  import lrukv_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/lrukv_lane.sv
// One entry of the store: key, data, recency rank and valid bit with its update logic.
module lrukv_lane
  import lrukv_pkg::*;
#(
  parameter int unsigned DEPTH     = 8,
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lane_cmd_t                  cmd,
  input  logic [KEY_BITS-1:0]        req_key,
  input  logic [DATA_BITS-1:0]       req_data,
  input  logic [$clog2(DEPTH)-1:0]   hit_rank,
  output logic                       valid,
  output logic                       match,
  output logic [KEY_BITS-1:0]        key,
  output logic [DATA_BITS-1:0]       data,
  output logic [$clog2(DEPTH)-1:0]   rank
);

  localparam int unsigned RK_W = $clog2(DEPTH);
  localparam logic [RK_W-1:0] RK_MAX = RK_W'(DEPTH - 1);

  logic                 valid_r, valid_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [DATA_BITS-1:0] data_r, data_nxt;
  logic [RK_W-1:0]      rank_r, rank_nxt;

  // Compare against the request key
  assign match = valid_r && (key_r == req_key);

  // Work out the next entry contents
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    data_nxt  = data_r;
    rank_nxt  = rank_r;
    if (cmd.age && valid_r && (rank_r != RK_MAX)) begin
      rank_nxt = rank_r + RK_W'(1);
    end
    if (cmd.promote && valid_r && (rank_r < hit_rank)) begin
      rank_nxt = rank_r + RK_W'(1);
    end
    if (cmd.sel) begin
      rank_nxt = '0;
      if (cmd.wr) begin
        data_nxt = req_data;
      end
    end
    if (cmd.drop) begin
      valid_nxt = 1'b0;
    end
    if (cmd.fill) begin
      valid_nxt = 1'b1;
      key_nxt   = req_key;
      data_nxt  = req_data;
      rank_nxt  = '0;
    end
  end

  // Valid bit is control state; payload holds no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    data_r <= data_nxt;
    rank_r <= rank_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign data  = data_r;
  assign rank  = rank_r;

endmodule

>>> src/lru_key_value_store_unit.sv
// Top level: fully associative LRU key/data store with request, result and capacity ports.
//
//   channel  | dir | handshake     | beat carries
//   ---------+-----+---------------+-----------------------------------------
//   in_req   | in  | valid/ready   | mode, key, write_data
//   out_rsp  | out | valid/ready   | hit, read_data, evicted, evicted_key
//   cfg_wr   | in  | valid/ready   | capacity (4 bits), ready always high
//
// One beat per cycle sustained while out_rsp.ready holds high; a request beat
// passes the request register, then one compare and rank update pass over all
// DEPTH lanes into the result register. The lanes are compared in parallel,
// so the key match, the rank update and the free-slot pick set the path length.
// Reset clears every valid bit and the occupancy and sets capacity to 8; no
// clearing pass is needed. A stalled result holds its register and the request
// register still takes one more beat before in_req.ready drops.
module lru_key_value_store_unit
  import lrukv_pkg::*;
#(
  parameter int unsigned DEPTH     = 8,
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  lrukv_req_if.sink   in_req,
  lrukv_rsp_if.source out_rsp,
  lrukv_cfg_if.sink   cfg_wr
);

  localparam int unsigned RK_W  = $clog2(DEPTH);
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  // Capacity register
  logic [CAP_W-1:0] capacity_r;

  // Request register
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_mode_r;
  logic [KEY_BITS-1:0]  s1_key_r;
  logic [DATA_BITS-1:0] s1_wdata_r;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [DATA_BITS-1:0] out_rdata_r, out_rdata_nxt;
  logic                 out_ev_r, out_ev_nxt;
  logic [KEY_BITS-1:0]  out_evkey_r, out_evkey_nxt;

  // Occupancy
  logic [OCC_W-1:0] occ_r, occ_nxt;

  // Lane signals
  lane_cmd_t            lane_cmd  [DEPTH];
  logic [KEY_BITS-1:0]  lane_key  [DEPTH];
  logic [DATA_BITS-1:0] lane_data [DEPTH];
  logic [RK_W-1:0]      lane_rank [DEPTH];
  logic [DEPTH-1:0]     valid_vec;
  logic [DEPTH-1:0]     match_vec;
  logic [DEPTH-1:0]     lru_vec;
  logic [DEPTH-1:0]     drop_vec;
  logic [DEPTH-1:0]     free_vec;
  logic [DEPTH-1:0]     slot_vec;

  // Control pass
  logic                 adv, go, hit, is_write, full, evict, insert;
  logic [CMP_W-1:0]     cap_ext, eff_cap;
  logic [RK_W-1:0]      hit_rank, lru_rank;
  logic [DATA_BITS-1:0] hit_data;
  logic [KEY_BITS-1:0]  lru_key;

  // Handshake: advance the pass when the result register is free or draining
  assign adv            = !out_valid_r || out_rsp.ready;
  assign go             = s1_valid_r && adv;
  assign in_req.ready   = !s1_valid_r || adv;
  assign cfg_wr.ready   = 1'b1;

  // Capacity write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_wr.valid) begin
      capacity_r <= cfg_wr.data;
    end
  end

  // Request register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_req.valid && in_req.ready) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_mode_r  <= in_req.mode;
      s1_key_r   <= in_req.key;
      s1_wdata_r <= in_req.write_data;
    end
  end

  // Lanes
  for (genvar g = 0; g < DEPTH; g++) begin : g_lane
    lrukv_lane #(
      .DEPTH     (DEPTH),
      .KEY_BITS  (KEY_BITS),
      .DATA_BITS (DATA_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (lane_cmd[g]),
      .req_key  (s1_key_r),
      .req_data (s1_wdata_r),
      .hit_rank (hit_rank),
      .valid    (valid_vec[g]),
      .match    (match_vec[g]),
      .key      (lane_key[g]),
      .data     (lane_data[g]),
      .rank     (lane_rank[g])
    );
  end

  // Clamp capacity to 1..DEPTH and test for a full store
  assign cap_ext  = CMP_W'(capacity_r);
  assign eff_cap  = (capacity_r == '0) ? CMP_W'(1) :
                    ((cap_ext > DEPTH_C) ? DEPTH_C : cap_ext);
  assign full     = CMP_W'(occ_r) >= eff_cap;
  assign lru_rank = RK_W'(occ_r - OCC_W'(1));

  assign hit      = |match_vec;
  assign is_write = (s1_mode_r == MODE_WRITE);
  assign evict    = !hit && is_write && full;
  assign insert   = !hit && is_write;

  // Ranks of valid entries run 0..occ-1, so the least recent holds occ-1
  always_comb begin
    hit_rank = '0;
    hit_data = '0;
    lru_key  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      lru_vec[i] = valid_vec[i] && (lane_rank[i] == lru_rank);
      hit_rank   = hit_rank | (lane_rank[i] & {RK_W{match_vec[i]}});
      hit_data   = hit_data | (lane_data[i] & {DATA_BITS{match_vec[i]}});
      lru_key    = lru_key  | (lane_key[i]  & {KEY_BITS{lru_vec[i]}});
    end
  end

  // Pick the lowest free lane after the eviction
  assign drop_vec = lru_vec & {DEPTH{evict}};
  assign free_vec = ~(valid_vec & ~drop_vec);
  assign slot_vec = free_vec & (~free_vec + DEPTH'(1));

  // Build the lane commands
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lane_cmd[i].promote = go && hit;
      lane_cmd[i].age     = go && insert;
      lane_cmd[i].sel     = go && match_vec[i];
      lane_cmd[i].wr      = is_write;
      lane_cmd[i].drop    = go && drop_vec[i];
      lane_cmd[i].fill    = go && insert && slot_vec[i];
    end
  end

  // Occupancy: an insert adds one unless it follows an eviction
  always_comb begin
    occ_nxt = occ_r;
    if (go && insert && !evict) begin
      occ_nxt = occ_r + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_rdata_nxt = out_rdata_r;
    out_ev_nxt    = out_ev_r;
    out_evkey_nxt = out_evkey_r;
    if (go) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = hit;
      out_rdata_nxt = (hit && !is_write) ? hit_data : '0;
      out_ev_nxt    = evict;
      out_evkey_nxt = evict ? lru_key : '0;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r   <= out_hit_nxt;
    out_rdata_r <= out_rdata_nxt;
    out_ev_r    <= out_ev_nxt;
    out_evkey_r <= out_evkey_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.hit         = out_hit_r;
  assign out_rsp.read_data   = out_rdata_r;
  assign out_rsp.evicted     = out_ev_r;
  assign out_rsp.evicted_key = out_evkey_r;

  // Keys of valid entries are distinct
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("more than one entry matches the request key");

  // Occupancy tracks the valid bits
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(occ_r))
    else $error("occupancy differs from the number of valid entries");

  // An eviction leaves occupancy unchanged
  a_evict_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (go && evict) |=> (occ_r == $past(occ_r)))
    else $error("occupancy changed across an eviction");

  // An eviction is reported only on a write miss
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_r) |-> !out_hit_r)
    else $error("eviction reported together with a hit");

endmodule
